@@ src/htsc_pkg.sv @@
package htsc_pkg;

  localparam logic [15:0] SYL_BASE = 16'd44032;
  localparam logic [15:0] JA_BASE  = 16'd12593;
  localparam logic [15:0] MO_BASE  = 16'd12623;
  localparam logic [7:0]  KEY_BS    = 8'd127;
  localparam logic [7:0]  KEY_FLUSH = 8'd0;

  localparam int N_JUNG = 21;
  localparam int N_JONG = 28;
  localparam int N_JA   = 30;
  localparam int N_CHO  = 19;

  localparam int DEF_QUEUE_DEPTH = 2;

  typedef logic [4:0] idx_t;

  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_LETTER,
    KIND_BACKSPACE
  } kind_t;

  // one classified keystroke as it waits between front and back
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  key;
    logic [15:0] jamo;
  } entry_t;

  localparam logic [15:0] KEY_PLAIN [0:25] = '{
    16'd12609, 16'd12640, 16'd12618, 16'd12615, 16'd12599, 16'd12601, 16'd12622,
    16'd12631, 16'd12625, 16'd12627, 16'd12623, 16'd12643, 16'd12641, 16'd12636,
    16'd12624, 16'd12628, 16'd12610, 16'd12593, 16'd12596, 16'd12613, 16'd12629,
    16'd12621, 16'd12616, 16'd12620, 16'd12635, 16'd12619};

  // first component of each consonant jamo
  localparam logic [15:0] JA_FIRST [0:29] = '{
    16'd12593, 16'd12594, 16'd12593, 16'd12596, 16'd12596, 16'd12596, 16'd12599,
    16'd12600, 16'd12601, 16'd12601, 16'd12601, 16'd12601, 16'd12601, 16'd12601,
    16'd12601, 16'd12601, 16'd12609, 16'd12610, 16'd12611, 16'd12610, 16'd12613,
    16'd12614, 16'd12615, 16'd12616, 16'd12617, 16'd12618, 16'd12619, 16'd12620,
    16'd12621, 16'd12622};

  // first component of each vowel jamo
  localparam logic [15:0] MO_FIRST [0:20] = '{
    16'd12623, 16'd12624, 16'd12625, 16'd12626, 16'd12627, 16'd12628, 16'd12629,
    16'd12630, 16'd12631, 16'd12631, 16'd12631, 16'd12631, 16'd12635, 16'd12636,
    16'd12636, 16'd12636, 16'd12636, 16'd12640, 16'd12641, 16'd12641, 16'd12643};

  // initial index of a consonant, second part for clusters
  localparam idx_t CHO_OF [0:29] = '{
    5'd0, 5'd1, 5'd9, 5'd2, 5'd12, 5'd18, 5'd3, 5'd4, 5'd5, 5'd0,
    5'd6, 5'd7, 5'd9, 5'd16, 5'd17, 5'd18, 5'd6, 5'd7, 5'd8, 5'd9,
    5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18};

  // final index of a consonant, zero when it cannot close a syllable
  localparam idx_t JONG_OF [0:29] = '{
    5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd0, 5'd8, 5'd9,
    5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd0, 5'd18,
    5'd19, 5'd20, 5'd21, 5'd22, 5'd0, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27};

  localparam logic [15:0] INV_CHO [0:18] = '{
    16'd12593, 16'd12594, 16'd12596, 16'd12599, 16'd12600, 16'd12601, 16'd12609,
    16'd12610, 16'd12611, 16'd12613, 16'd12614, 16'd12615, 16'd12616, 16'd12617,
    16'd12618, 16'd12619, 16'd12620, 16'd12621, 16'd12622};

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic logic [15:0] key_jamo(input logic [7:0] c);
    logic        shifted;
    logic [4:0]  idx;
    logic [15:0] j;
    shifted = c < 8'd97;
    idx = shifted ? 5'(c - 8'd65) : 5'(c - 8'd97);
    j = (idx < 5'd26) ? KEY_PLAIN[idx] : 16'd0;
    // shifted keys give the double consonants and the yae/ye vowels
    if (shifted) begin
      case (idx)
        5'd4, 5'd16, 5'd17, 5'd19, 5'd22: j = j + 16'd1;
        5'd14, 5'd15:                     j = j + 16'd2;
        default:                          j = j;
      endcase
    end
    return j;
  endfunction

  function automatic idx_t ja_idx(input logic [15:0] j);
    return (j >= JA_BASE && j < JA_BASE + 16'(N_JA)) ? 5'(j - JA_BASE) : 5'd0;
  endfunction

  function automatic idx_t mo_idx(input logic [15:0] j);
    return (j >= MO_BASE && j < MO_BASE + 16'(N_JUNG)) ? 5'(j - MO_BASE) : 5'd0;
  endfunction

  // offset from the first consonant to the cluster, zero if they do not join
  function automatic logic [2:0] join_ja(input idx_t a, input idx_t b);
    logic [2:0] k;
    case ({a, b})
      {5'd0,  5'd20}: k = 3'd2;
      {5'd3,  5'd23}: k = 3'd1;
      {5'd3,  5'd29}: k = 3'd2;
      {5'd8,  5'd0}:  k = 3'd1;
      {5'd8,  5'd16}: k = 3'd2;
      {5'd8,  5'd17}: k = 3'd3;
      {5'd8,  5'd20}: k = 3'd4;
      {5'd8,  5'd27}: k = 3'd5;
      {5'd8,  5'd28}: k = 3'd6;
      {5'd8,  5'd29}: k = 3'd7;
      {5'd17, 5'd20}: k = 3'd2;
      default:        k = 3'd0;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] join_mo(input idx_t a, input idx_t b);
    logic [2:0] k;
    case ({a, b})
      {5'd8,  5'd0}:  k = 3'd1;
      {5'd8,  5'd1}:  k = 3'd2;
      {5'd8,  5'd20}: k = 3'd3;
      {5'd13, 5'd4}:  k = 3'd1;
      {5'd13, 5'd5}:  k = 3'd2;
      {5'd13, 5'd20}: k = 3'd3;
      {5'd18, 5'd20}: k = 3'd1;
      default:        k = 3'd0;
    endcase
    return k;
  endfunction

endpackage

@@ src/hangul_two_set_composer_unit.sv @@
// path: a key's first code point passes the key queue and then the output register
//   before it shows on m_*; a second code point is held until the first is taken
// throughput: one key per cycle while m_* accepts; a key giving two code points
//   holds the composer until it loads the second, which the key queue (QUEUE_DEPTH
//   entries) absorbs while it has room; with the default two entries input waits
// reset: synchronous rst empties the queue and output and clears the pending syllable
module hangul_two_set_composer_unit #(
  parameter int QUEUE_DEPTH = htsc_pkg::DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] key_code
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] code_point
  output logic        m_tlast
);

  logic             push;
  logic             full;
  logic             empty;
  logic             pop;
  htsc_pkg::entry_t push_data;
  htsc_pkg::entry_t pop_data;

  htsc_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .full     (full),
    .push     (push),
    .entry    (push_data)
  );

  htsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  htsc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (!empty),
    .q_data   (pop_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

@@ src/htsc_front.sv @@
module htsc_front (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] key_code
  input  logic                full,
  output logic                push,
  output htsc_pkg::entry_t    entry
);

  assign s_tready = !full;
  assign push     = s_tvalid && !full;

  always_comb begin
    entry.key  = s_tdata;
    entry.jamo = 16'd0;
    if (s_tdata == htsc_pkg::KEY_BS) begin
      entry.kind = htsc_pkg::KIND_BACKSPACE;
    end else if (htsc_pkg::is_letter(s_tdata)) begin
      entry.kind = htsc_pkg::KIND_LETTER;
      entry.jamo = htsc_pkg::key_jamo(s_tdata);
    end else begin
      entry.kind = htsc_pkg::KIND_OTHER;
    end
  end

endmodule

@@ src/htsc_queue.sv @@
module htsc_queue #(
  parameter int DEPTH = htsc_pkg::DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  htsc_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output htsc_pkg::entry_t pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  htsc_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers wrap at the last entry so any depth works
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ src/htsc_back.sv @@
module htsc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  htsc_pkg::entry_t q_data,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,
  output logic             m_tlast
);

  // composer state; cho/jung/jong mirror the indices of a pending syllable
  logic [15:0]     pending;
  logic [15:0]     last_jamo;
  htsc_pkg::idx_t  cho;
  htsc_pkg::idx_t  jung;
  htsc_pkg::idx_t  jong;
  logic [15:0]     pending_next;
  logic [15:0]     last_next;
  htsc_pkg::idx_t  cho_next;
  htsc_pkg::idx_t  jung_next;
  htsc_pkg::idx_t  jong_next;

  // output register plus one held second result
  logic            out_valid;
  logic [15:0]     out_data;
  logic            out_last;
  logic            sec_valid;
  logic [15:0]     sec_data;

  logic [1:0]      n;
  logic [15:0]     r0;
  logic [15:0]     r1;

  logic [15:0]     x;
  logic            lv;
  logic            xv;
  logic            p_syl;
  htsc_pkg::idx_t  l_ja;
  htsc_pkg::idx_t  l_mo;
  htsc_pkg::idx_t  x_ja;
  htsc_pkg::idx_t  x_mo;
  logic [15:0]     l_jf;
  logic [15:0]     l_mf;
  htsc_pkg::idx_t  lmf_mo;
  htsc_pkg::idx_t  jong_l;
  htsc_pkg::idx_t  jong_x;
  htsc_pkg::idx_t  jong_lf;
  logic [2:0]      k;
  logic [15:0]     com;
  htsc_pkg::idx_t  com_mo;
  htsc_pkg::idx_t  jong_com;
  logic [15:0]     lone_cho;
  logic [15:0]     syl;

  assign pop = q_valid && !sec_valid && (!out_valid || m_tready);

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

  always_comb begin
    x        = q_data.jamo;
    lv       = last_jamo >= htsc_pkg::MO_BASE;
    xv       = x >= htsc_pkg::MO_BASE;
    p_syl    = pending >= htsc_pkg::SYL_BASE;
    l_ja     = htsc_pkg::ja_idx(last_jamo);
    l_mo     = htsc_pkg::mo_idx(last_jamo);
    x_ja     = htsc_pkg::ja_idx(x);
    x_mo     = htsc_pkg::mo_idx(x);
    l_jf     = htsc_pkg::JA_FIRST[l_ja];
    l_mf     = htsc_pkg::MO_FIRST[l_mo];
    lmf_mo   = htsc_pkg::mo_idx(l_mf);
    jong_l   = htsc_pkg::JONG_OF[l_ja];
    jong_x   = htsc_pkg::JONG_OF[x_ja];
    jong_lf  = htsc_pkg::JONG_OF[htsc_pkg::ja_idx(l_jf)];
    k        = xv ? htsc_pkg::join_mo(l_mo, x_mo) : htsc_pkg::join_ja(l_ja, x_ja);
    com      = last_jamo + 16'(k);
    com_mo   = htsc_pkg::mo_idx(com);
    jong_com = htsc_pkg::JONG_OF[htsc_pkg::ja_idx(com)];
    lone_cho = (cho < 5'(htsc_pkg::N_CHO)) ? htsc_pkg::INV_CHO[cho] : 16'd0;
    syl      = htsc_pkg::SYL_BASE
             + 16'(htsc_pkg::CHO_OF[l_ja]) * 16'(htsc_pkg::N_JUNG * htsc_pkg::N_JONG)
             + 16'(x_mo) * 16'(htsc_pkg::N_JONG);
  end

  always_comb begin
    n            = 2'd0;
    r0           = pending;
    r1           = {8'd0, q_data.key};
    pending_next = pending;
    last_next    = last_jamo;
    cho_next     = cho;
    jung_next    = jung;
    jong_next    = jong;
    unique case (q_data.kind)
      htsc_pkg::KIND_BACKSPACE: begin
        if (pending == 16'd0) begin
          n  = 2'd1;
          r0 = {8'd0, htsc_pkg::KEY_BS};
        end else if (!p_syl) begin
          pending_next = 16'd0;
          last_next    = 16'd0;
        end else if (lv) begin
          if (l_mf == last_jamo) begin
            // simple vowel: back to the initial consonant alone
            pending_next = lone_cho;
            last_next    = lone_cho;
          end else begin
            pending_next = pending
                         - 16'(3'(last_jamo - l_mf)) * 16'(htsc_pkg::N_JONG);
            last_next    = l_mf;
            jung_next    = lmf_mo;
          end
        end else begin
          if (l_jf == last_jamo) begin
            pending_next = pending - 16'(jong_l);
            last_next    = htsc_pkg::MO_BASE + 16'(jung);
            jong_next    = 5'd0;
          end else begin
            pending_next = pending + 16'(jong_lf) - 16'(jong_l);
            last_next    = l_jf;
            jong_next    = jong_lf;
          end
        end
      end
      htsc_pkg::KIND_LETTER: begin
        if (pending == 16'd0) begin
          pending_next = x;
          last_next    = x;
        end else if (lv == xv) begin
          if (k == 3'd0) begin
            n            = 2'd1;
            pending_next = x;
            last_next    = x;
          end else begin
            if (!p_syl) begin
              pending_next = com;
            end else if (xv) begin
              pending_next = pending + 16'(k) * 16'(htsc_pkg::N_JONG);
              jung_next    = com_mo;
            end else begin
              pending_next = pending + 16'(jong_com) - 16'(jong_l);
              jong_next    = jong_com;
            end
            last_next = com;
          end
        end else if (!xv) begin
          if (!p_syl || jong_x == 5'd0) begin
            n            = 2'd1;
            pending_next = x;
            last_next    = x;
          end else begin
            pending_next = pending + 16'(jong_x);
            last_next    = x;
            jong_next    = jong_x;
          end
        end else begin
          // vowel after a consonant: the final (or second part of a cluster) moves over
          if (p_syl) begin
            n  = 2'd1;
            r0 = pending - 16'(jong_l) + ((l_jf != last_jamo) ? 16'(jong_lf) : 16'd0);
          end else if (l_jf != last_jamo) begin
            n  = 2'd1;
            r0 = l_jf;
          end
          pending_next = syl;
          last_next    = x;
          cho_next     = htsc_pkg::CHO_OF[l_ja];
          jung_next    = x_mo;
          jong_next    = 5'd0;
        end
      end
      default: begin
        pending_next = 16'd0;
        if (pending != 16'd0 && q_data.key != htsc_pkg::KEY_FLUSH) begin
          n = 2'd2;
        end else if (pending != 16'd0) begin
          n = 2'd1;
        end else if (q_data.key != htsc_pkg::KEY_FLUSH) begin
          n  = 2'd1;
          r0 = {8'd0, q_data.key};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 16'd0;
      last_jamo <= 16'd0;
      out_valid <= 1'b0;
      sec_valid <= 1'b0;
    end else begin
      if (pop) begin
        pending   <= pending_next;
        last_jamo <= last_next;
        out_valid <= n != 2'd0;
        sec_valid <= n == 2'd2;
      end else if (out_valid && m_tready) begin
        out_valid <= sec_valid;
        sec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cho      <= cho_next;
      jung     <= jung_next;
      jong     <= jong_next;
      out_data <= r0;
      out_last <= n != 2'd2;
      sec_data <= r1;
    end else if (out_valid && m_tready && sec_valid) begin
      out_data <= sec_data;
      out_last <= 1'b1;
    end
  end

endmodule

@@ src/htsc_checker.sv @@
module htsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  a_out_idle_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_in_ready_after_reset: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // the second code point of a key follows at once
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
    else $error("second result of a key missing");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata <= 16'd55203)
    else $error("code point beyond the last syllable");

endmodule

bind hangul_two_set_composer_unit htsc_checker u_checker (.*);
